/* hw/rtl/gic_pkg.sv */
// Shared types and constants for the GPIO interrupt controller.
package gic_pkg;

    localparam int GROUP_COUNT = 7;
    localparam int GRP_W = 3;
    localparam int BIT_W = 5;
    localparam int IRQ_W = 7;

    localparam logic [11:0] POLARITY_BASE = 12'd128;
    localparam logic [11:0] PENDING_BASE  = 12'd160;
    localparam logic [11:0] ENABLE_BASE   = 12'd192;
    localparam logic [11:0] TYPE_BASE     = 12'd224;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_DRIVE = 2'd2,
        OP_FLIP  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_WRITE,
        CMD_DRIVE,
        CMD_FLIP,
        CMD_UNKNOWN,
        CMD_NOP
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BANK_POL,
        BANK_PEND,
        BANK_EN,
        BANK_TYPE
    } bank_t;

    typedef struct packed {
        cmd_kind_t        kind;
        bank_t            bank;
        logic [GRP_W-1:0] grp;
        logic [BIT_W-1:0] bit_idx;
        logic [31:0]      data;
        logic             level;
    } cmd_t;

endpackage

/* hw/rtl/gpio_interrupt_controller.sv */
// GPIO interrupt controller: seven groups of 32 lines, each edge or level triggered.
//
// Input channel (in_valid/in_ready) carries one operation per transfer: bus
// read, bus write, line drive or autoflip consume. Output channel
// (out_valid/out_ready) returns exactly one result per input transfer, in
// order: read data, unknown-offset flag, autoflip flag and the per-group
// interrupt vector taken after the operation.
//
// From input transfer to result valid, an operation passes through the command
// queue, then the execution stage that updates the register banks and loads
// the result register. Throughput is one transfer per cycle while the receiver
// does not stall the result register; every operation touches at most one group.
//
// Reset clears all banks, the line levels, the driven masks, the queue and
// the result valid flag. When the receiver stalls, the result register holds,
// the two-entry queue keeps taking transfers until full, then in_ready drops.
module gpio_interrupt_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 opcode,
    input  logic [11:0]                reg_offset,
    input  logic [31:0]                write_data,
    input  logic [7:0]                 line_index,
    input  logic                       line_level,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [31:0]                read_data,
    output logic                       unknown_access,
    output logic                       autoflip_taken,
    output logic [gic_pkg::IRQ_W-1:0]  group_irq
);
    import gic_pkg::*;

    cmd_t dec_cmd;
    cmd_t q_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign in_ready = !q_full;

    gic_front u_front (
        .opcode     (opcode),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .line_index (line_index),
        .line_level (line_level),
        .cmd        (dec_cmd)
    );

    gic_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_cmd  (dec_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (q_cmd)
    );

    gic_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_valid),
        .cmd            (q_cmd),
        .cmd_pop        (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .unknown_access (unknown_access),
        .autoflip_taken (autoflip_taken),
        .group_irq      (group_irq)
    );

endmodule

/* hw/rtl/gic_front.sv */
// Front end: decode one transfer into a command for the execution stage.
module gic_front (
    input  logic [1:0]      opcode,
    input  logic [11:0]     reg_offset,
    input  logic [31:0]     write_data,
    input  logic [7:0]      line_index,
    input  logic            line_level,
    output gic_pkg::cmd_t   cmd
);
    import gic_pkg::*;

    function automatic logic bank_hit(input logic [11:0] off, input logic [11:0] base);
        logic [11:0] rel;
        rel = off - base;
        return (off >= base) && (rel[1:0] == 2'b00) && (rel[11:2] < 10'(GROUP_COUNT));
    endfunction

    logic [11:0] rel_pol;
    logic [11:0] rel_pend;
    logic [11:0] rel_en;
    logic [11:0] rel_type;
    logic [GRP_W-1:0] line_grp;

    assign rel_pol  = reg_offset - POLARITY_BASE;
    assign rel_pend = reg_offset - PENDING_BASE;
    assign rel_en   = reg_offset - ENABLE_BASE;
    assign rel_type = reg_offset - TYPE_BASE;
    assign line_grp = line_index[7:5];

    always_comb
    begin
        cmd.kind    = CMD_NOP;
        cmd.bank    = BANK_POL;
        cmd.grp     = '0;
        cmd.bit_idx = line_index[BIT_W-1:0];
        cmd.data    = write_data;
        cmd.level   = line_level;
        unique case (opcode_t'(opcode))
            OP_READ, OP_WRITE:
            begin
                cmd.kind = (opcode_t'(opcode) == OP_READ) ? CMD_READ : CMD_WRITE;
                priority if (bank_hit(reg_offset, POLARITY_BASE))
                begin
                    cmd.bank = BANK_POL;
                    cmd.grp  = rel_pol[GRP_W+1:2];
                end
                else if (bank_hit(reg_offset, PENDING_BASE))
                begin
                    cmd.bank = BANK_PEND;
                    cmd.grp  = rel_pend[GRP_W+1:2];
                end
                else if (bank_hit(reg_offset, ENABLE_BASE))
                begin
                    cmd.bank = BANK_EN;
                    cmd.grp  = rel_en[GRP_W+1:2];
                end
                else if (bank_hit(reg_offset, TYPE_BASE))
                begin
                    cmd.bank = BANK_TYPE;
                    cmd.grp  = rel_type[GRP_W+1:2];
                end
                else
                begin
                    cmd.kind = CMD_UNKNOWN;
                end
            end
            OP_DRIVE, OP_FLIP:
            begin
                cmd.grp = line_grp;
                if ({1'b0, line_grp} < (GRP_W+1)'(GROUP_COUNT))
                    cmd.kind = (opcode_t'(opcode) == OP_DRIVE) ? CMD_DRIVE : CMD_FLIP;
                else
                    cmd.kind = CMD_NOP;
            end
            default:
            begin
                cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

/* hw/rtl/gic_fifo.sv */
// Two-entry command queue between the decode and execution stages.
module gic_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gic_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output gic_pkg::cmd_t pop_cmd
);
    import gic_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* hw/rtl/gic_back.sv */
// Execution stage: register banks, line tracking and the result register.
module gic_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  gic_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 read_data,
    output logic                        unknown_access,
    output logic                        autoflip_taken,
    output logic [gic_pkg::IRQ_W-1:0]   group_irq
);
    import gic_pkg::*;

    logic [31:0] raw_reg  [GROUP_COUNT];
    logic [31:0] drv_reg  [GROUP_COUNT];
    logic [31:0] pend_reg [GROUP_COUNT];
    logic [31:0] en_reg   [GROUP_COUNT];
    logic [31:0] pol_reg  [GROUP_COUNT];
    logic [31:0] typ_reg  [GROUP_COUNT];
    logic [31:0] raw_next  [GROUP_COUNT];
    logic [31:0] drv_next  [GROUP_COUNT];
    logic [31:0] pend_next [GROUP_COUNT];
    logic [31:0] en_next   [GROUP_COUNT];
    logic [31:0] pol_next  [GROUP_COUNT];
    logic [31:0] typ_next  [GROUP_COUNT];

    logic             out_valid_reg;
    logic [31:0]      rdata_reg;
    logic             unknown_reg;
    logic             taken_reg;
    logic [IRQ_W-1:0] irq_reg;

    logic             fire;
    logic             upd;
    logic             latch;
    logic [31:0]      bit_mask;
    logic [31:0]      c_raw, c_drv, c_pend, c_en, c_pol, c_typ;
    logic [31:0]      n_raw, n_drv, n_pend, n_en, n_pol, n_typ;
    logic             was, first, is_level;
    logic [31:0]      rdata;
    logic             unknown;
    logic             taken;
    logic [IRQ_W-1:0] irq;

    assign fire    = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_pop = fire;

    assign c_raw    = raw_reg[cmd.grp];
    assign c_drv    = drv_reg[cmd.grp];
    assign c_pend   = pend_reg[cmd.grp];
    assign c_en     = en_reg[cmd.grp];
    assign c_pol    = pol_reg[cmd.grp];
    assign c_typ    = typ_reg[cmd.grp];
    assign bit_mask = 32'd1 << cmd.bit_idx;
    assign was      = |(c_raw & bit_mask);
    assign first    = ~|(c_drv & bit_mask);
    assign is_level = |(c_typ & bit_mask);

    always_comb
    begin
        n_raw   = c_raw;
        n_drv   = c_drv;
        n_pend  = c_pend;
        n_en    = c_en;
        n_pol   = c_pol;
        n_typ   = c_typ;
        latch   = 1'b0;
        upd     = 1'b0;
        rdata   = '0;
        unknown = 1'b0;
        taken   = 1'b0;
        unique case (cmd.kind)
            CMD_READ:
            begin
                unique case (cmd.bank)
                    BANK_POL:  rdata = c_pol;
                    BANK_PEND: rdata = c_pend;
                    BANK_EN:   rdata = c_en;
                    BANK_TYPE: rdata = c_typ;
                    default:   rdata = '0;
                endcase
            end
            CMD_WRITE:
            begin
                upd   = 1'b1;
                latch = 1'b1;
                unique case (cmd.bank)
                    BANK_POL:  n_pol  = cmd.data;
                    BANK_PEND: n_pend = c_pend & ~cmd.data;
                    BANK_EN:   n_en   = cmd.data;
                    BANK_TYPE: n_typ  = cmd.data;
                    default:   n_pol  = c_pol;
                endcase
            end
            CMD_DRIVE:
            begin
                upd   = 1'b1;
                n_raw = cmd.level ? (c_raw | bit_mask) : (c_raw & ~bit_mask);
                n_drv = c_drv | bit_mask;
                if (is_level)
                    latch = (cmd.level != was) || first;
                else if (cmd.level && !was)
                    n_pend = c_pend | bit_mask;
            end
            CMD_FLIP:
            begin
                if (is_level)
                begin
                    upd    = 1'b1;
                    taken  = 1'b1;
                    n_raw  = cmd.level ? (c_raw | bit_mask) : (c_raw & ~bit_mask);
                    n_drv  = c_drv | bit_mask;
                    n_pend = c_pend & ~bit_mask;
                    n_pol  = cmd.level ? (c_pol & ~bit_mask) : (c_pol | bit_mask);
                end
            end
            CMD_UNKNOWN:
            begin
                unknown = 1'b1;
            end
            default:
            begin
                upd = 1'b0;
            end
        endcase
        if (latch)
            n_pend = n_pend | (~(n_raw ^ n_pol) & n_typ & n_drv & n_en);
    end

    always_comb
    begin
        raw_next  = raw_reg;
        drv_next  = drv_reg;
        pend_next = pend_reg;
        en_next   = en_reg;
        pol_next  = pol_reg;
        typ_next  = typ_reg;
        if (fire && upd)
        begin
            raw_next[cmd.grp]  = n_raw;
            drv_next[cmd.grp]  = n_drv;
            pend_next[cmd.grp] = n_pend;
            en_next[cmd.grp]   = n_en;
            pol_next[cmd.grp]  = n_pol;
            typ_next[cmd.grp]  = n_typ;
        end
        irq = '0;
        for (int g = 0; g < IRQ_W; g++)
        begin
            if (g < GROUP_COUNT)
                irq[g] = |(pend_next[g] & en_next[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                raw_reg[g]  <= '0;
                drv_reg[g]  <= '0;
                pend_reg[g] <= '0;
                en_reg[g]   <= '0;
                pol_reg[g]  <= '0;
                typ_reg[g]  <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            raw_reg  <= raw_next;
            drv_reg  <= drv_next;
            pend_reg <= pend_next;
            en_reg   <= en_next;
            pol_reg  <= pol_next;
            typ_reg  <= typ_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rdata_reg   <= rdata;
            unknown_reg <= unknown;
            taken_reg   <= taken;
            irq_reg     <= irq;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = rdata_reg;
    assign unknown_access = unknown_reg;
    assign autoflip_taken = taken_reg;
    assign group_irq      = irq_reg;

endmodule

/* hw/rtl/gic_checker.sv */
// Port-level checks for the GPIO interrupt controller and their binding.
module gic_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [31:0]                read_data,
    input  logic                       unknown_access,
    input  logic                       autoflip_taken,
    input  logic [gic_pkg::IRQ_W-1:0]  group_irq
);
    import gic_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(group_irq))
        else $error("stalled result changed");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(unknown_access && autoflip_taken))
        else $error("unknown access and autoflip flagged together");

    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unknown_access |-> read_data == 32'd0)
        else $error("undecoded access returned data");

    a_flip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && autoflip_taken |-> read_data == 32'd0)
        else $error("autoflip result carried read data");

endmodule

bind gpio_interrupt_controller gic_checker u_gic_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .unknown_access (unknown_access),
    .autoflip_taken (autoflip_taken),
    .group_irq      (group_irq)
);

/* tb/gic_checker.sv */
// Scoreboard for the GPIO interrupt controller: predicts every result and compares it.
module gic_scoreboard (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [1:0]                opcode,
    input  logic [11:0]               reg_offset,
    input  logic [31:0]               write_data,
    input  logic [7:0]                line_index,
    input  logic                      line_level,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [31:0]               read_data,
    input  logic                      unknown_access,
    input  logic                      autoflip_taken,
    input  logic [gic_pkg::IRQ_W-1:0] group_irq,
    output int                        mismatch_count,
    output int                        results_due
);
    import gic_pkg::*;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [31:0]      rdata;
        logic             unknown;
        logic             taken;
        logic [IRQ_W-1:0] irq;
    } gic_result_t;

    typedef struct {
        logic  hit;
        bank_t bank;
        int    grp;
    } reg_slot_t;

    logic [31:0] line_state      [GROUP_COUNT];
    logic [31:0] driven_lines    [GROUP_COUNT];
    logic [31:0] pending_word    [GROUP_COUNT];
    logic [31:0] enable_word     [GROUP_COUNT];
    logic [31:0] polarity_word   [GROUP_COUNT];
    logic [31:0] level_type_word [GROUP_COUNT];

    gic_result_t expected_results[$];

    function automatic int bank_group(logic [11:0] off, logic [11:0] base);
        logic [11:0] rel;
        if (off < base)
        begin
            return -1;
        end
        rel = off - base;
        if (rel[1:0] != 2'b00 || (rel >> 2) >= GROUP_COUNT)
        begin
            return -1;
        end
        return int'(rel >> 2);
    endfunction

    function automatic reg_slot_t decode_register(logic [11:0] off);
        reg_slot_t slot;
        slot.hit = 1'b1;
        slot.bank = BANK_POL;
        slot.grp = bank_group(off, POLARITY_BASE);
        if (slot.grp >= 0)
        begin
            return slot;
        end
        slot.bank = BANK_PEND;
        slot.grp = bank_group(off, PENDING_BASE);
        if (slot.grp >= 0)
        begin
            return slot;
        end
        slot.bank = BANK_EN;
        slot.grp = bank_group(off, ENABLE_BASE);
        if (slot.grp >= 0)
        begin
            return slot;
        end
        slot.bank = BANK_TYPE;
        slot.grp = bank_group(off, TYPE_BASE);
        if (slot.grp >= 0)
        begin
            return slot;
        end
        slot.hit = 1'b0;
        slot.grp = 0;
        return slot;
    endfunction

    function automatic void sample_level_lines(int g);
        pending_word[g] |= ~(line_state[g] ^ polarity_word[g]) & level_type_word[g] &
                           driven_lines[g] & enable_word[g];
    endfunction

    function automatic void record_level(int g, logic [31:0] bit_mask, logic lvl);
        if (lvl)
        begin
            line_state[g] |= bit_mask;
        end
        else
        begin
            line_state[g] &= ~bit_mask;
        end
        driven_lines[g] |= bit_mask;
    endfunction

    function automatic gic_result_t execute_operation(logic [1:0] op_bits, logic [11:0] off,
                                                      logic [31:0] data, logic [7:0] line,
                                                      logic lvl);
        gic_result_t res;
        reg_slot_t   slot;
        opcode_t     op;
        int          g;
        logic [31:0] bit_mask;
        logic        was_high;
        logic        first_drive;
        logic        is_level;
        res = '0;
        op = opcode_t'(op_bits);
        if (op == OP_READ || op == OP_WRITE)
        begin
            slot = decode_register(off);
            if (!slot.hit)
            begin
                res.unknown = 1'b1;
            end
            else if (op == OP_READ)
            begin
                case (slot.bank)
                    BANK_POL:  res.rdata = polarity_word[slot.grp];
                    BANK_PEND: res.rdata = pending_word[slot.grp];
                    BANK_EN:   res.rdata = enable_word[slot.grp];
                    default:   res.rdata = level_type_word[slot.grp];
                endcase
            end
            else
            begin
                case (slot.bank)
                    BANK_POL:  polarity_word[slot.grp] = data;
                    BANK_PEND: pending_word[slot.grp] &= ~data;
                    BANK_EN:   enable_word[slot.grp] = data;
                    default:   level_type_word[slot.grp] = data;
                endcase
                sample_level_lines(slot.grp);
            end
        end
        else
        begin
            g = int'(line[7:5]);
            if (g < GROUP_COUNT)
            begin
                bit_mask = 32'd1 << line[4:0];
                is_level = (level_type_word[g] & bit_mask) != 32'd0;
                if (op == OP_DRIVE)
                begin
                    was_high = (line_state[g] & bit_mask) != 32'd0;
                    first_drive = (driven_lines[g] & bit_mask) == 32'd0;
                    record_level(g, bit_mask, lvl);
                    if (is_level)
                    begin
                        if (lvl != was_high || first_drive)
                        begin
                            sample_level_lines(g);
                        end
                    end
                    else if (lvl && !was_high)
                    begin
                        pending_word[g] |= bit_mask;
                    end
                end
                else if (is_level)
                begin
                    record_level(g, bit_mask, lvl);
                    pending_word[g] &= ~bit_mask;
                    if (lvl)
                    begin
                        polarity_word[g] &= ~bit_mask;
                    end
                    else
                    begin
                        polarity_word[g] |= bit_mask;
                    end
                    res.taken = 1'b1;
                end
            end
        end
        for (int k = 0; k < GROUP_COUNT && k < IRQ_W; k++)
        begin
            if ((pending_word[k] & enable_word[k]) != 32'd0)
            begin
                res.irq[k] = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
        begin
            $display("mismatch at %0t: %s got %h expected %h", $time, field, got, want);
        end
    endtask

    task automatic check_result();
        gic_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with no transfer outstanding", read_data, 32'd0);
            return;
        end
        want = expected_results.pop_front();
        if (read_data !== want.rdata)
        begin
            report_mismatch("read_data", read_data, want.rdata);
        end
        if (unknown_access !== want.unknown)
        begin
            report_mismatch("unknown_access", 32'(unknown_access), 32'(want.unknown));
        end
        if (autoflip_taken !== want.taken)
        begin
            report_mismatch("autoflip_taken", 32'(autoflip_taken), 32'(want.taken));
        end
        if (group_irq !== want.irq)
        begin
            report_mismatch("group_irq", 32'(group_irq), 32'(want.irq));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                line_state[g] = '0;
                driven_lines[g] = '0;
                pending_word[g] = '0;
                enable_word[g] = '0;
                polarity_word[g] = '0;
                level_type_word[g] = '0;
            end
            expected_results.delete();
            mismatch_count = 0;
            results_due <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result();
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(execute_operation(opcode, reg_offset, write_data,
                                                             line_index, line_level));
            end
            results_due <= expected_results.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Top of the GPIO interrupt controller testbench: clock, reset, stimulus and verdict.
module tb_top;
    import gic_pkg::*;

    localparam int TOTAL_ITEMS    = 1275;
    localparam int QUIET_FROM     = 1120;
    localparam int LONG_HOLD_AT   = 400;
    localparam int LONG_HOLD_LEN  = 48;
    localparam int TIMEOUT_CYCLES = 400000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          opcode;
    logic [11:0]         reg_offset;
    logic [31:0]         write_data;
    logic [7:0]          line_index;
    logic                line_level;
    logic                out_valid;
    logic                out_ready;
    logic [31:0]         read_data;
    logic                unknown_access;
    logic                autoflip_taken;
    logic [IRQ_W-1:0]    group_irq;
    int                  mismatch_count;
    int                  results_due;
    int                  items_sent = 0;
    logic                quiet_tail = 1'b0;
    logic                long_hold_done = 1'b0;

    gpio_interrupt_controller dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .reg_offset     (reg_offset),
        .write_data     (write_data),
        .line_index     (line_index),
        .line_level     (line_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .unknown_access (unknown_access),
        .autoflip_taken (autoflip_taken),
        .group_irq      (group_irq)
    );

    gic_scoreboard u_scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .reg_offset     (reg_offset),
        .write_data     (write_data),
        .line_index     (line_index),
        .line_level     (line_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .unknown_access (unknown_access),
        .autoflip_taken (autoflip_taken),
        .group_irq      (group_irq),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always #6 clk = ~clk;

    function automatic logic [11:0] bank_offset(bank_t b, logic [2:0] g);
        logic [11:0] base;
        case (b)
            BANK_POL:  base = POLARITY_BASE;
            BANK_PEND: base = PENDING_BASE;
            BANK_EN:   base = ENABLE_BASE;
            default:   base = TYPE_BASE;
        endcase
        return base + {7'd0, g, 2'b00};
    endfunction

    function automatic logic [31:0] pattern_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom & $urandom;
            3:       return $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(opcode_t op, logic [11:0] off, logic [31:0] data,
                             logic [7:0] line, logic lvl);
        if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        reg_offset <= off;
        write_data <= data;
        line_index <= line;
        line_level <= lvl;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off, none in the tail
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && !long_hold_done && items_sent >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_LEN) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [2:0] grp;
        logic [4:0] bit_sel;
        logic [7:0] line;
        int         pick;
        bank_t      bank;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        opcode     <= OP_READ;
        reg_offset <= '0;
        write_data <= '0;
        line_index <= '0;
        line_level <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bank extremes, edge and level lines, autoflip, ignored lines, bad offsets
        send_item(OP_READ,  bank_offset(BANK_POL, 3'd0), 32'hFFFF_FFFF, 8'd0, 1'b0);
        send_item(OP_READ,  bank_offset(BANK_TYPE, 3'd6), 32'h0, 8'd255, 1'b1);
        send_item(OP_WRITE, bank_offset(BANK_EN, 3'd0), 32'hFFFF_FFFF, 8'd0, 1'b0);
        send_item(OP_WRITE, bank_offset(BANK_TYPE, 3'd0), 32'hFFFF_0000, 8'd0, 1'b0);
        send_item(OP_WRITE, bank_offset(BANK_POL, 3'd0), 32'hAAAA_0000, 8'd0, 1'b0);
        send_item(OP_DRIVE, 12'd0, 32'h0, 8'd0, 1'b1);
        send_item(OP_DRIVE, 12'd0, 32'h0, 8'd0, 1'b1);
        send_item(OP_DRIVE, 12'd0, 32'h0, 8'd31, 1'b1);
        send_item(OP_DRIVE, 12'd0, 32'h0, 8'd16, 1'b0);
        send_item(OP_READ,  bank_offset(BANK_PEND, 3'd0), 32'h0, 8'd0, 1'b0);
        send_item(OP_WRITE, bank_offset(BANK_PEND, 3'd0), 32'hFFFF_FFFF, 8'd0, 1'b0);
        send_item(OP_READ,  bank_offset(BANK_PEND, 3'd0), 32'h0, 8'd0, 1'b0);
        send_item(OP_FLIP,  12'd0, 32'h0, 8'd31, 1'b1);
        send_item(OP_FLIP,  12'd0, 32'h0, 8'd0, 1'b1);
        send_item(OP_READ,  bank_offset(BANK_POL, 3'd0), 32'h0, 8'd0, 1'b0);
        send_item(OP_DRIVE, 12'd0, 32'h0, 8'd223, 1'b1);
        send_item(OP_DRIVE, 12'd0, 32'h0, 8'd224, 1'b1);
        send_item(OP_FLIP,  12'd0, 32'h0, 8'd255, 1'b0);
        send_item(OP_READ,  12'd129, 32'h0, 8'd0, 1'b0);
        send_item(OP_WRITE, 12'd0, 32'hFFFF_FFFF, 8'd0, 1'b0);
        send_item(OP_READ,  12'd4095, 32'h0, 8'd0, 1'b0);
        send_item(OP_READ,  12'd156, 32'h0, 8'd0, 1'b0);
        send_item(OP_WRITE, bank_offset(BANK_EN, 3'd6), 32'hFFFF_FFFF, 8'd0, 1'b0);
        send_item(OP_WRITE, bank_offset(BANK_POL, 3'd6), 32'h0, 8'd0, 1'b0);
        send_item(OP_WRITE, bank_offset(BANK_TYPE, 3'd6), 32'h0, 8'd0, 1'b0);

        // random: configure a group, then exercise its lines, with some noise
        while (items_sent < TOTAL_ITEMS)
        begin
            grp = 3'($urandom_range(0, GROUP_COUNT - 1));
            send_item(OP_WRITE, bank_offset(BANK_TYPE, grp), pattern_word(),
                      8'($urandom), 1'($urandom));
            send_item(OP_WRITE, bank_offset(BANK_EN, grp), pattern_word(),
                      8'($urandom), 1'($urandom));
            send_item(OP_WRITE, bank_offset(BANK_POL, grp), pattern_word(),
                      8'($urandom), 1'($urandom));
            repeat ($urandom_range(8, 24))
            begin
                quiet_tail = (items_sent >= QUIET_FROM);
                pick = $urandom_range(0, 99);
                bit_sel = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7))
                                                     : 5'($urandom_range(0, 31));
                line = {grp, bit_sel};
                bank = bank_t'($urandom_range(0, 3));
                if (pick < 42)
                begin
                    send_item(OP_DRIVE, 12'($urandom), $urandom, line, 1'($urandom));
                end
                else if (pick < 56)
                begin
                    send_item(OP_FLIP, 12'($urandom), $urandom, line, 1'($urandom));
                end
                else if (pick < 70)
                begin
                    send_item(OP_READ, bank_offset(bank, grp), $urandom,
                              8'($urandom), 1'($urandom));
                end
                else if (pick < 78)
                begin
                    send_item(OP_WRITE, bank_offset(BANK_PEND, grp), pattern_word(),
                              8'($urandom), 1'($urandom));
                end
                else if (pick < 88)
                begin
                    send_item(OP_WRITE,
                              bank_offset(bank, 3'($urandom_range(0, GROUP_COUNT - 1))),
                              pattern_word(), 8'($urandom), 1'($urandom));
                end
                else
                begin
                    send_item(opcode_t'($urandom_range(0, 3)), 12'($urandom), $urandom,
                              8'($urandom), 1'($urandom));
                end
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/gic_pkg.sv
hw/rtl/gic_front.sv
hw/rtl/gic_fifo.sv
hw/rtl/gic_back.sv
hw/rtl/gpio_interrupt_controller.sv
hw/rtl/gic_checker.sv
tb/gic_checker.sv
tb/tb_top.sv
